// ----- hdl/frq_pkg.sv -----
package frq_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int SLOT_W = 6;
  localparam int VRT_W = 64;
  localparam int PRIO_W = 2;
  localparam int COUNT_W = 7;
  localparam int LOAD_W = 10;
  localparam int LAG_W = 32;
  localparam int SLOT_SPACE = 64;
  localparam logic [LAG_W-1:0] LAG_RESET = 32'd1024;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_POP = 2'd1;
  localparam logic [1:0] MODE_RM  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] thread_slot;
    logic [VRT_W-1:0]  thread_vruntime;
    logic [PRIO_W-1:0] thread_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  out_slot;
    logic [VRT_W-1:0]   out_vruntime;
    logic [PRIO_W-1:0]  out_priority;
    logic [COUNT_W-1:0] queue_count;
    logic [LOAD_W-1:0]  queue_load;
    logic [VRT_W-1:0]   queue_min_vruntime;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [VRT_W-1:0]  vrt;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_INS,
    RD_SRCH,
    RD_SH
  } rd_sel_t;

  typedef enum logic [2:0] {
    K_DUP,
    K_FULL,
    K_NONE,
    K_MISS,
    K_INS,
    K_TAKE
  } fin_kind_t;

  typedef struct packed {
    logic      accept;
    rd_sel_t   rd_sel;
    logic      ins_shift;
    logic      ins_new;
    logic      srch_next;
    logic      take;
    logic      sh_step;
    logic      finish;
    fin_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic mark_hit;
    logic empty;
    logic full;
    logic brk;
    logic ptr_one;
    logic match;
    logic more;
    logic sh_more;
  } dp_sts_t;

  function automatic logic [LOAD_W-1:0] load_of(input logic [PRIO_W-1:0] prio);
    logic [3:0] w;
    w = 4'd1 << prio;
    return LOAD_W'(w);
  endfunction

endpackage

// ----- hdl/frq_ram.sv -----
module frq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/frq_ctrl.sv -----
module frq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      mode,
  input  frq_pkg::dp_sts_t sts,
  output frq_pkg::dp_cmd_t cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [2:0] {
    IDLE,
    INS_CMP,
    INS_WR,
    SRCH,
    SHIFT,
    FIN
  } state_t;

  state_t             state, state_next;
  frq_pkg::fin_kind_t kind, kind_next;

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    cmd           = '0;
    cmd.rd_sel    = frq_pkg::RD_IDLE;
    cmd.kind      = kind;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = FIN;
          case (mode)
            frq_pkg::MODE_ENQ: begin
              if (sts.mark_hit) begin
                kind_next = frq_pkg::K_DUP;
              end else if (sts.full) begin
                kind_next = frq_pkg::K_FULL;
              end else if (sts.empty) begin
                state_next = INS_WR;
              end else begin
                state_next = INS_CMP;
              end
            end
            frq_pkg::MODE_POP: begin
              if (sts.empty) begin
                kind_next = frq_pkg::K_NONE;
              end else begin
                state_next = SRCH;
              end
            end
            frq_pkg::MODE_RM: begin
              if (!sts.mark_hit) begin
                kind_next = frq_pkg::K_MISS;
              end else begin
                state_next = SRCH;
              end
            end
            default: begin
              kind_next = frq_pkg::K_NONE;
            end
          endcase
        end
      end
      INS_CMP: begin
        cmd.rd_sel = frq_pkg::RD_INS;
        if (sts.brk) begin
          cmd.ins_shift = 1'b1;
          if (sts.ptr_one) begin
            state_next = INS_WR;
          end
        end else begin
          cmd.ins_new = 1'b1;
          kind_next   = frq_pkg::K_INS;
          state_next  = FIN;
        end
      end
      INS_WR: begin
        cmd.ins_new = 1'b1;
        kind_next   = frq_pkg::K_INS;
        state_next  = FIN;
      end
      SRCH: begin
        cmd.rd_sel = frq_pkg::RD_SRCH;
        if (sts.match) begin
          cmd.take   = 1'b1;
          kind_next  = frq_pkg::K_TAKE;
          state_next = sts.more ? SHIFT : FIN;
        end else begin
          cmd.srch_next = 1'b1;
        end
      end
      SHIFT: begin
        cmd.rd_sel  = frq_pkg::RD_SH;
        cmd.sh_step = 1'b1;
        if (!sts.sh_more) begin
          state_next = FIN;
        end
      end
      FIN: begin
        cmd.finish = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      kind  <= frq_pkg::K_NONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      done  <= (state == FIN);
    end
  end

  assign busy = (state != IDLE);

endmodule

// ----- hdl/frq_dp.sv -----
module frq_dp #(
  parameter int QUEUE_DEPTH = frq_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  frq_pkg::in_item_t           item,
  input  logic                        cfg_we,
  input  logic [frq_pkg::LAG_W-1:0]   cfg_data,
  input  frq_pkg::dp_cmd_t            cmd,
  output frq_pkg::dp_sts_t            sts,
  output frq_pkg::out_item_t          result
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [frq_pkg::LAG_W-1:0]      lag_limit;
  logic [frq_pkg::SLOT_SPACE-1:0] mark, mark_next;
  logic [frq_pkg::COUNT_W-1:0]    count, count_next;
  logic [frq_pkg::LOAD_W-1:0]     load, load_next;
  logic [frq_pkg::VRT_W-1:0]      min_vrt, min_next;
  logic [AW-1:0]                  ptr;
  logic [frq_pkg::SLOT_W-1:0]     cur_slot;
  logic [frq_pkg::VRT_W-1:0]      cur_vrt;
  logic [frq_pkg::PRIO_W-1:0]     cur_prio;
  logic                           cur_pop;
  logic [frq_pkg::VRT_W-1:0]      ins_vrt;
  frq_pkg::entry_t                tk;
  logic                           took0;
  logic [frq_pkg::VRT_W-1:0]      head_vrt;
  logic                           at_head;

  logic [frq_pkg::VRT_W-1:0]      raised;
  logic [frq_pkg::LOAD_W-1:0]     ld_ins, ld_tk;
  frq_pkg::entry_t                rd, wdata;
  logic [AW-1:0]                  raddr;
  logic                           we;
  logic [$bits(frq_pkg::entry_t)-1:0] rdata_raw;

  frq_ram #(
    .WIDTH($bits(frq_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(ptr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rd = frq_pkg::entry_t'(rdata_raw);

  always_comb begin
    raised = item.thread_vruntime;
    if ((min_vrt > item.thread_vruntime) &&
        ((min_vrt - item.thread_vruntime) > {32'd0, lag_limit})) begin
      raised = min_vrt;
    end
  end

  assign sts.mark_hit = mark[item.thread_slot];
  assign sts.empty    = (count == '0);
  assign sts.full     = (32'(count) >= 32'(QUEUE_DEPTH));
  assign sts.brk      = (ins_vrt < rd.vrt) || ((ins_vrt == rd.vrt) && (cur_prio > rd.prio));
  assign sts.ptr_one  = (ptr == AW'(1));
  assign sts.match    = cur_pop || (rd.slot == cur_slot);
  assign sts.more     = (32'(ptr) + 32'd1) < 32'(count);
  assign sts.sh_more  = (32'(ptr) + 32'd2) < 32'(count);

  always_comb begin
    case (cmd.rd_sel)
      frq_pkg::RD_IDLE: raddr = (item.mode == frq_pkg::MODE_ENQ) ? AW'(count - 7'd1) : '0;
      frq_pkg::RD_INS:  raddr = ptr - AW'(2);
      frq_pkg::RD_SRCH: raddr = ptr + AW'(1);
      frq_pkg::RD_SH:   raddr = ptr + AW'(2);
      default:          raddr = '0;
    endcase
  end

  assign we = cmd.ins_shift | cmd.ins_new | cmd.sh_step;

  always_comb begin
    wdata = rd;
    if (cmd.ins_new) begin
      wdata.slot = cur_slot;
      wdata.vrt  = ins_vrt;
      wdata.prio = cur_prio;
    end
  end

  assign ld_ins = frq_pkg::load_of(cur_prio);
  assign ld_tk  = frq_pkg::load_of(tk.prio);

  always_comb begin
    mark_next  = mark;
    count_next = count;
    load_next  = load;
    min_next   = min_vrt;
    if (cmd.finish) begin
      case (cmd.kind)
        frq_pkg::K_INS: begin
          mark_next[cur_slot] = 1'b1;
          count_next = count + 7'd1;
          load_next  = load + ld_ins;
          if (at_head) begin
            min_next = ins_vrt;
          end
        end
        frq_pkg::K_TAKE: begin
          mark_next[tk.slot] = 1'b0;
          count_next = (count != '0) ? count - 7'd1 : '0;
          load_next  = (load >= ld_tk) ? load - ld_tk : '0;
          if (count_next == '0) begin
            min_next = (tk.vrt > min_vrt) ? tk.vrt : min_vrt;
          end else if (took0) begin
            min_next = head_vrt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_limit <= frq_pkg::LAG_RESET;
      mark      <= '0;
      count     <= '0;
      load      <= '0;
      min_vrt   <= '0;
    end else begin
      if (cfg_we) begin
        lag_limit <= cfg_data;
      end
      mark    <= mark_next;
      count   <= count_next;
      load    <= load_next;
      min_vrt <= min_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_slot <= item.thread_slot;
      cur_vrt  <= item.thread_vruntime;
      cur_prio <= item.thread_priority;
      cur_pop  <= (item.mode == frq_pkg::MODE_POP);
      ins_vrt  <= raised;
      ptr      <= (item.mode == frq_pkg::MODE_ENQ) ? AW'(count) : '0;
    end
    if (cmd.ins_shift) begin
      ptr <= ptr - AW'(1);
    end
    if (cmd.ins_new) begin
      at_head <= (ptr == '0);
    end
    if (cmd.srch_next) begin
      ptr <= ptr + AW'(1);
    end
    if (cmd.take) begin
      tk    <= rd;
      took0 <= (ptr == '0);
    end
    if (cmd.sh_step) begin
      ptr <= ptr + AW'(1);
      if (ptr == '0) begin
        head_vrt <= rd.vrt;
      end
    end
    if (cmd.finish) begin
      result.queue_count        <= count_next;
      result.queue_load         <= load_next;
      result.queue_min_vruntime <= min_next;
      case (cmd.kind)
        frq_pkg::K_DUP, frq_pkg::K_FULL: begin
          result.status       <= (cmd.kind == frq_pkg::K_DUP) ? frq_pkg::ST_DUP : frq_pkg::ST_FULL;
          result.out_slot     <= cur_slot;
          result.out_vruntime <= cur_vrt;
          result.out_priority <= cur_prio;
        end
        frq_pkg::K_MISS: begin
          result.status       <= frq_pkg::ST_EMPTY;
          result.out_slot     <= cur_slot;
          result.out_vruntime <= '0;
          result.out_priority <= '0;
        end
        frq_pkg::K_INS: begin
          result.status       <= frq_pkg::ST_DONE;
          result.out_slot     <= cur_slot;
          result.out_vruntime <= ins_vrt;
          result.out_priority <= cur_prio;
        end
        frq_pkg::K_TAKE: begin
          result.status       <= frq_pkg::ST_DONE;
          result.out_slot     <= tk.slot;
          result.out_vruntime <= tk.vrt;
          result.out_priority <= tk.prio;
        end
        default: begin
          result.status       <= frq_pkg::ST_EMPTY;
          result.out_slot     <= '0;
          result.out_vruntime <= '0;
          result.out_priority <= '0;
        end
      endcase
    end
  end

endmodule

// ----- hdl/fair_run_queue_top.sv -----
// Operation: items that change nothing finish without touching the order memory; an
// enqueue walks from the tail, one entry at a time, until it finds its place, and a pop
// or remove searches from the head and then shifts the later entries up to close the gap.
// Throughput: one item at a time; the walk moves one entry per cycle through the
// single read and single write port of the order memory. done is a one-cycle strobe.
// Reset: synchronous, empties the queue, lag_limit returns to 1024; no clearing pass.
module fair_run_queue_top #(
  parameter int QUEUE_DEPTH = frq_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  frq_pkg::in_item_t         item,
  output logic                      busy,
  output logic                      done,
  output frq_pkg::out_item_t        result,
  input  logic                      cfg_we,
  input  logic [frq_pkg::LAG_W-1:0] cfg_data
);

  frq_pkg::dp_cmd_t cmd;
  frq_pkg::dp_sts_t sts;

  frq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (item.mode),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  frq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule
